>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the formatter modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ITPA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never hold
`define ITPA_NEVER(label, expr, msg) \
  `ITPA_ASSERT(label, !(expr), msg)

`endif

>>> hdl/itpa_pkg.sv
// ----------------------------------------------------------------------------
// itpa_pkg
// types, codes and character helpers for the padded integer formatter
// ----------------------------------------------------------------------------
package itpa_pkg;

  localparam int MAX_OUT_CHARS_DEF = 64;
  localparam int QUEUE_DEPTH_DEF   = 2;

  // digit positions held by the back end
  localparam int NDEC = 20;
  localparam int NHEX = 16;

  // conversion kinds
  localparam logic [2:0] KIND_D     = 3'd0;
  localparam logic [2:0] KIND_I     = 3'd1;
  localparam logic [2:0] KIND_U     = 3'd2;
  localparam logic [2:0] KIND_XLOW  = 3'd3;
  localparam logic [2:0] KIND_XUP   = 3'd4;
  localparam logic [2:0] KIND_PTR   = 3'd5;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_LOWA  = 8'h61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_STRIP,
    ST_PAD,
    ST_PRE,
    ST_DIG
  } st_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [63:0] mag;     // magnitude, d/i values sit in the upper half
    logic        hex;     // base 16, else base 10
    logic        short32; // only 32 bits to convert
    logic        upper;   // upper-case hex letters
    logic        neg;     // minus sign
    logic        prefix;  // 0x prefix
  } item_t;

  function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = CH_ZERO + {4'b0, nib};
    end else if (upper) begin
      ch = CH_UPA + {4'b0, nib - 4'd10};
    end else begin
      ch = CH_LOWA + {4'b0, nib - 4'd10};
    end
    return ch;
  endfunction

endpackage

>>> hdl/integer_to_padded_ascii.sv
// sequence: one item is taken from the queue, shifted through the bcd register for u
//   and d/i (hex skips the conversion), stripped of leading zero digits, then sent
//   one character per cycle into the output register while out_stall allows
// occupancy: the back end takes no new item until the last one is fully sent, as it
//   has one shared bcd shift register and a one-character output port
// reset: synchronous rst empties the queue, idles the back end, drops out_valid
// ----------------------------------------------------------------------------
// integer_to_padded_ascii
// printf-style d/i/u/x/X/p formatter with left space padding, one char per beat
// ----------------------------------------------------------------------------
module integer_to_padded_ascii #(
  parameter int MAX_OUT_CHARS = itpa_pkg::MAX_OUT_CHARS_DEF,
  parameter int QUEUE_DEPTH   = itpa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] value,
  input  logic [2:0]  conv_kind,
  input  logic [6:0]  field_width,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        last_char
);
  import itpa_pkg::*;

  localparam int WW = $clog2(MAX_OUT_CHARS + 1);
  localparam int DW = $bits(item_t) + WW;

  item_t         f_item;
  logic [WW-1:0] f_width;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;
  logic [DW-1:0] q_data;
  item_t         q_item;
  logic [WW-1:0] q_width;

  itpa_front #(
    .MAX_OUT_CHARS (MAX_OUT_CHARS),
    .WW            (WW)
  ) u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .value       (value),
    .conv_kind   (conv_kind),
    .field_width (field_width),
    .q_full      (q_full),
    .push        (push),
    .item        (f_item),
    .width       (f_width)
  );

  itpa_queue #(
    .DW    (DW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({f_width, f_item}),
    .pop   (pop),
    .rdata (q_data),
    .full  (q_full),
    .empty (q_empty)
  );

  assign q_item  = q_data[$bits(item_t)-1:0];
  assign q_width = q_data[DW-1 -: WW];

  itpa_back #(
    .MAX_OUT_CHARS (MAX_OUT_CHARS),
    .WW            (WW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_item    (q_item),
    .q_width   (q_width),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .last_char (last_char)
  );

endmodule

>>> hdl/itpa_front.sv
// ----------------------------------------------------------------------------
// itpa_front
// accepts input beats, classifies the conversion and clamps the width
// ----------------------------------------------------------------------------
module itpa_front #(
  parameter int MAX_OUT_CHARS = itpa_pkg::MAX_OUT_CHARS_DEF,
  parameter int WW            = $clog2(MAX_OUT_CHARS + 1)
) (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [63:0]          value,
  input  logic [2:0]           conv_kind,
  input  logic [6:0]           field_width,
  input  logic                 q_full,
  output logic                 push,
  output itpa_pkg::item_t      item,
  output logic [WW-1:0]        width
);
  import itpa_pkg::*;

  localparam int CW = (WW > 7) ? WW : 7;

  logic [CW-1:0] fw_ext;
  logic          signed_kind;
  logic [31:0]   low;
  logic [31:0]   mag32;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  assign fw_ext = CW'(field_width);
  assign width  = (fw_ext > CW'(MAX_OUT_CHARS)) ? WW'(MAX_OUT_CHARS) : WW'(fw_ext);

  assign signed_kind = (conv_kind == KIND_D) || (conv_kind == KIND_I);
  assign low         = value[31:0];
  assign mag32       = low[31] ? (32'd0 - low) : low;

  always_comb begin
    item = '0;
    case (conv_kind)
      KIND_D, KIND_I: begin
        item.mag     = {mag32, 32'd0};
        item.short32 = 1'b1;
        item.neg     = low[31];
      end
      KIND_U: begin
        item.mag = value;
      end
      KIND_XLOW: begin
        item.mag = value;
        item.hex = 1'b1;
      end
      KIND_PTR: begin
        item.mag    = value;
        item.hex    = 1'b1;
        item.prefix = 1'b1;
      end
      default: begin
        // X and the unused codes
        item.mag   = value;
        item.hex   = 1'b1;
        item.upper = 1'b1;
      end
    endcase
    if (!signed_kind) begin
      item.neg = 1'b0;
    end
  end

endmodule

>>> hdl/itpa_queue.sv
// ----------------------------------------------------------------------------
// itpa_queue
// short register queue between the front and back ends
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itpa_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = itpa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output logic          full,
  output logic          empty
);
  import itpa_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [DW-1:0]   mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;

  assign full  = (count == CNTW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `ITPA_NEVER(a_q_overflow, push && full && !pop, "push into full queue")
  `ITPA_NEVER(a_q_underflow, pop && empty, "pop from empty queue")
  `ITPA_ASSERT(a_q_count, (push && !pop) |=> (count == $past(count) + 1'b1), "count slip")

endmodule

>>> hdl/itpa_back.sv
// ----------------------------------------------------------------------------
// itpa_back
// converts one queued item to digits and sends its characters
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itpa_back #(
  parameter int MAX_OUT_CHARS = itpa_pkg::MAX_OUT_CHARS_DEF,
  parameter int WW            = $clog2(MAX_OUT_CHARS + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  itpa_pkg::item_t q_item,
  input  logic [WW-1:0]   q_width,
  input  logic            q_empty,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_char,
  output logic            last_char
);
  import itpa_pkg::*;

  localparam int BW = 4 * NDEC;

  st_t           state, state_next;
  logic [63:0]   sreg, sreg_next;
  logic [BW-1:0] bcd, bcd_next;
  logic [BW-1:0] adj;
  logic [6:0]    cnt, cnt_next;
  logic [4:0]    ndig, ndig_next;
  logic [WW-1:0] pad_cnt, pad_cnt_next;
  logic [WW-1:0] width_r, width_r_next;
  logic          neg, neg_next;
  logic          prefix, prefix_next;
  logic          upper, upper_next;
  logic          pre_idx, pre_idx_next;
  logic          out_valid_next;
  logic [7:0]    out_char_next;
  logic          last_char_next;
  logic          adv;
  logic [1:0]    plen;
  logic [WW-1:0] used;
  logic [3:0]    top_nib;

  assign adv     = !out_valid || !out_stall;
  assign plen    = neg ? 2'd1 : (prefix ? 2'd2 : 2'd0);
  assign used    = WW'(ndig) + WW'(plen);
  assign top_nib = bcd[BW-1 -: 4];

  // add-3 correction on every bcd digit before the shift
  always_comb begin
    for (int i = 0; i < NDEC; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    sreg      <= sreg_next;
    bcd       <= bcd_next;
    cnt       <= cnt_next;
    ndig      <= ndig_next;
    pad_cnt   <= pad_cnt_next;
    width_r   <= width_r_next;
    neg       <= neg_next;
    prefix    <= prefix_next;
    upper     <= upper_next;
    pre_idx   <= pre_idx_next;
    out_char  <= out_char_next;
    last_char <= last_char_next;
  end

  always_comb begin
    state_next     = state;
    sreg_next      = sreg;
    bcd_next       = bcd;
    cnt_next       = cnt;
    ndig_next      = ndig;
    pad_cnt_next   = pad_cnt;
    width_r_next   = width_r;
    neg_next       = neg;
    prefix_next    = prefix;
    upper_next     = upper;
    pre_idx_next   = pre_idx;
    pop            = 1'b0;
    out_valid_next = out_stall ? out_valid : 1'b0;
    out_char_next  = out_char;
    last_char_next = last_char;

    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          pop          = 1'b1;
          width_r_next = q_width;
          neg_next     = q_item.neg;
          prefix_next  = q_item.prefix;
          upper_next   = q_item.upper;
          pre_idx_next = 1'b0;
          sreg_next    = q_item.mag;
          if (q_item.hex) begin
            bcd_next   = {q_item.mag, (BW - 64)'(0)};
            ndig_next  = 5'(NHEX);
            state_next = ST_STRIP;
          end else begin
            bcd_next   = '0;
            ndig_next  = 5'(NDEC);
            cnt_next   = q_item.short32 ? 7'd32 : 7'd64;
            state_next = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        bcd_next  = {adj[BW-2:0], sreg[63]};
        sreg_next = {sreg[62:0], 1'b0};
        cnt_next  = cnt - 1'b1;
        if (cnt == 7'd1) begin
          state_next = ST_STRIP;
        end
      end
      ST_STRIP: begin
        // drop leading zero digits, keep at least one
        if ((ndig > 5'd1) && (top_nib == 4'd0)) begin
          bcd_next  = {bcd[BW-5:0], 4'd0};
          ndig_next = ndig - 1'b1;
        end else if (width_r > used) begin
          pad_cnt_next = width_r - used;
          state_next   = ST_PAD;
        end else if (plen != 2'd0) begin
          state_next = ST_PRE;
        end else begin
          state_next = ST_DIG;
        end
      end
      ST_PAD: begin
        if (adv) begin
          out_valid_next = 1'b1;
          out_char_next  = CH_SPACE;
          last_char_next = 1'b0;
          pad_cnt_next   = pad_cnt - 1'b1;
          if (pad_cnt == WW'(1)) begin
            state_next = (plen != 2'd0) ? ST_PRE : ST_DIG;
          end
        end
      end
      ST_PRE: begin
        if (adv) begin
          out_valid_next = 1'b1;
          last_char_next = 1'b0;
          if (neg) begin
            out_char_next = CH_MINUS;
            state_next    = ST_DIG;
          end else if (!pre_idx) begin
            out_char_next = CH_ZERO;
            pre_idx_next  = 1'b1;
          end else begin
            out_char_next = CH_X;
            state_next    = ST_DIG;
          end
        end
      end
      ST_DIG: begin
        if (adv) begin
          out_valid_next = 1'b1;
          out_char_next  = digit_char(top_nib, upper);
          last_char_next = (ndig == 5'd1);
          bcd_next       = {bcd[BW-5:0], 4'd0};
          ndig_next      = ndig - 1'b1;
          if (ndig == 5'd1) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `ITPA_NEVER(a_pad_zero, (state == ST_PAD) && (pad_cnt == '0), "pad state with zero count")
  `ITPA_NEVER(a_dig_zero, (state == ST_DIG) && (ndig == '0), "digit state with no digits")
  `ITPA_ASSERT(a_pop_idle, pop |-> (state == ST_IDLE), "pop outside idle")

endmodule
